// File: rtl/core/aal_pkg.sv
`timescale 1ns / 1ps

package aal_pkg;

  // ledger geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 48;
  localparam int DATA_W  = 64;
  localparam int CFG_W   = 5;

  // request operation codes
  typedef enum logic [2:0] {
    MODE_RECV    = 3'd0,
    MODE_SEND    = 3'd1,
    MODE_PROVE   = 3'd2,
    MODE_RELEASE = 3'd3,
    MODE_ERASE   = 3'd4,
    MODE_QUERY   = 3'd5
  } mode_t;

  // result status codes
  typedef enum logic [2:0] {
    STAT_RECORDED = 3'd0,
    STAT_ALLOWED  = 3'd1,
    STAT_INVALID  = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_PROVEN   = 3'd4,
    STAT_OVERFLOW = 3'd5,
    STAT_LIMIT    = 3'd6,
    STAT_DONE     = 3'd7
  } status_t;

  // one account as held in the count memory
  typedef struct packed {
    logic [DATA_W-1:0] rec;
    logic [DATA_W-1:0] snt;
    logic              prv;
  } acct_t;

  // tag search result
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;
  } tag_look_t;

  // tag store update
  typedef struct packed {
    logic             clear;
    logic             alloc;
    logic             free;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
  } tag_upd_t;

  // registered arithmetic for one request
  typedef struct packed {
    acct_t           cur;
    logic [DATA_W:0] rec_sum;
    logic [DATA_W:0] snt_sum;
    logic [DATA_W-1:0] limit;
    logic [DATA_W:0] rec_dif;
    logic [DATA_W:0] snt_dif;
  } acct_calc_t;

endpackage

// File: rtl/core/aal_tags.sv
`timescale 1ns / 1ps

module aal_tags (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [aal_pkg::KEY_W-1:0]      look_key,
  input  logic [aal_pkg::CNT_W-1:0]      act,
  input  aal_pkg::tag_upd_t              upd,
  output aal_pkg::tag_look_t             look,
  output logic [aal_pkg::CNT_W-1:0]      cnt
);

  logic [aal_pkg::ENTRIES-1:0] used_r;
  logic [aal_pkg::KEY_W-1:0]   key_r [aal_pkg::ENTRIES];
  logic [aal_pkg::CNT_W-1:0]   cnt_r;

  // parallel key compare, lowest matching and lowest free entry within span
  always_comb begin
    look = '0;
    for (int i = aal_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (used_r[i] && (key_r[i] == look_key) && (int'(act) > i)) begin
        look.hit     = 1'b1;
        look.hit_idx = aal_pkg::IDX_W'(i);
      end
      if (!used_r[i] && (int'(act) > i)) begin
        look.free_ok  = 1'b1;
        look.free_idx = aal_pkg::IDX_W'(i);
      end
    end
  end

  // occupancy bits and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      cnt_r  <= '0;
    end else if (upd.clear) begin
      used_r <= '0;
      cnt_r  <= '0;
    end else if (upd.alloc) begin
      used_r[upd.idx] <= 1'b1;
      cnt_r           <= cnt_r + 1'b1;
    end else if (upd.free) begin
      used_r[upd.idx] <= 1'b0;
      cnt_r           <= cnt_r - 1'b1;
    end
  end

  // endpoint keys
  always_ff @(posedge clk) begin
    if (upd.alloc) begin
      key_r[upd.idx] <= upd.key;
    end
  end

  assign cnt = cnt_r;

  a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) == $countones(used_r))
    else $error("fill count differs from occupied entries");

  a_upd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(upd.alloc && upd.free))
    else $error("allocate and free in the same cycle");

  a_alloc_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    upd.alloc && !upd.clear |-> !used_r[upd.idx])
    else $error("allocation into an occupied entry");

endmodule

// File: rtl/core/aal_count_ram.sv
`timescale 1ns / 1ps

module aal_count_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [aal_pkg::IDX_W-1:0] waddr,
  input  aal_pkg::acct_t            wdata,
  input  logic                      re,
  input  logic [aal_pkg::IDX_W-1:0] raddr,
  output aal_pkg::acct_t            rdata
);

  aal_pkg::acct_t mem [aal_pkg::ENTRIES];
  aal_pkg::acct_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/aal_account.sv
`timescale 1ns / 1ps

module aal_account (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       hit,
  input  aal_pkg::acct_t             rdata,
  input  logic [aal_pkg::DATA_W-1:0] bytes,
  input  logic [aal_pkg::DATA_W-1:0] rel,
  output aal_pkg::acct_calc_t        calc
);

  aal_pkg::acct_t        cur;
  logic [aal_pkg::DATA_W+1:0] triple;
  aal_pkg::acct_calc_t   calc_nxt;
  aal_pkg::acct_calc_t   calc_r;

  // a fresh account starts from zero
  assign cur = hit ? rdata : '0;

  // sums, differences and the saturated three-times limit
  always_comb begin
    triple = {2'b00, cur.rec} + {1'b0, cur.rec, 1'b0};
    calc_nxt.cur     = cur;
    calc_nxt.rec_sum = {1'b0, cur.rec} + {1'b0, bytes};
    calc_nxt.snt_sum = {1'b0, cur.snt} + {1'b0, bytes};
    calc_nxt.limit   = (|triple[aal_pkg::DATA_W+1:aal_pkg::DATA_W]) ?
                       '1 : triple[aal_pkg::DATA_W-1:0];
    calc_nxt.rec_dif = {1'b0, cur.rec} - {1'b0, bytes};
    calc_nxt.snt_dif = {1'b0, cur.snt} - {1'b0, rel};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      calc_r <= calc_nxt;
    end
  end

  assign calc = calc_r;

endmodule

// File: rtl/core/anti_amplification_ledger.sv
`timescale 1ns / 1ps
// flow: a request is accepted only while idle, then runs in turn through key search
//   with count memory read, the arithmetic stage, then decision and write-back; the
//   next request is taken only after write-back, which waits while a held result is stalled
// reset: every entry is free (occupancy bits cleared at once, no clearing pass),
//   active_entries is 16 and no result is pending

module anti_amplification_ledger (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_mode,
  input  logic [47:0]                in_endpoint_key,
  input  logic [63:0]                in_byte_count,
  input  logic [63:0]                in_sent_release_count,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_status,
  output logic                       out_entry_found,
  output logic [63:0]                out_received_total,
  output logic [63:0]                out_sent_total,
  output logic                       out_proven_flag,
  output logic [4:0]                 out_entries_in_use,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [4:0]                 cfg_active_entries
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_CALC = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]                      mode_r;
  logic [aal_pkg::KEY_W-1:0]       key_r;
  logic [aal_pkg::DATA_W-1:0]      bytes_r;
  logic [aal_pkg::DATA_W-1:0]      rel_r;
  logic                            hit_r;
  logic                            room_r;
  logic [aal_pkg::IDX_W-1:0]       idx_r;
  logic [aal_pkg::CNT_W-1:0]       act_r;

  aal_pkg::tag_look_t              look;
  aal_pkg::tag_upd_t               upd;
  logic [aal_pkg::CNT_W-1:0]       tag_cnt;
  logic [aal_pkg::IDX_W-1:0]       look_idx;
  aal_pkg::acct_t                  ram_rdata;
  aal_pkg::acct_calc_t             calc;

  logic                            in_acc;
  logic                            cfg_we;
  logic                            cfg_ok;
  logic                            done_go;
  logic                            alloc, free, wr, keep;
  aal_pkg::status_t                st;
  aal_pkg::acct_t                  res;
  logic [aal_pkg::CNT_W-1:0]       cnt_after;

  logic                            out_valid_r;
  aal_pkg::status_t                out_status_r;
  logic                            out_found_r;
  aal_pkg::acct_t                  out_acct_r;
  logic [4:0]                      out_used_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_ok    = (cfg_active_entries != '0) &&
                     (int'(cfg_active_entries) <= aal_pkg::ENTRIES);
  assign done_go   = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign look_idx  = look.hit ? look.hit_idx : look.free_idx;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = ST_CALC;
      ST_CALC: state_nxt = ST_DONE;
      ST_DONE: if (done_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      act_r   <= aal_pkg::CNT_W'(aal_pkg::ENTRIES);
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_ok) begin
        act_r <= aal_pkg::CNT_W'(cfg_active_entries);
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= in_mode;
      key_r   <= in_endpoint_key;
      bytes_r <= in_byte_count;
      rel_r   <= in_sent_release_count;
    end
  end

  // search result, also the count memory write-back address
  always_ff @(posedge clk) begin
    if (state_r == ST_LOOK) begin
      hit_r  <= look.hit;
      room_r <= look.hit || look.free_ok;
      idx_r  <= look_idx;
    end
  end

  aal_tags u_tags (
    .clk      (clk),
    .rst_n    (rst_n),
    .look_key (key_r),
    .act      (act_r),
    .upd      (upd),
    .look     (look),
    .cnt      (tag_cnt)
  );

  aal_count_ram u_ram (
    .clk   (clk),
    .we    (wr && done_go),
    .waddr (idx_r),
    .wdata (res),
    .re    (state_r == ST_LOOK),
    .raddr (look_idx),
    .rdata (ram_rdata)
  );

  aal_account u_acct (
    .clk   (clk),
    .en    (state_r == ST_CALC),
    .hit   (hit_r),
    .rdata (ram_rdata),
    .bytes (bytes_r),
    .rel   (rel_r),
    .calc  (calc)
  );

  // per-operation decision
  always_comb begin
    st    = aal_pkg::STAT_DONE;
    res   = calc.cur;
    wr    = 1'b0;
    alloc = 1'b0;
    free  = 1'b0;
    keep  = hit_r;
    unique case (mode_r)
      aal_pkg::MODE_RECV: begin
        if (key_r == '0) begin
          st   = aal_pkg::STAT_INVALID;
          keep = 1'b0;
        end else if (!room_r) begin
          st   = aal_pkg::STAT_FULL;
          keep = 1'b0;
        end else begin
          keep  = 1'b1;
          alloc = !hit_r;
          wr    = 1'b1;
          if (calc.cur.prv) begin
            st = aal_pkg::STAT_PROVEN;
          end else if (calc.rec_sum[aal_pkg::DATA_W]) begin
            st = aal_pkg::STAT_OVERFLOW;
          end else begin
            res.rec = calc.rec_sum[aal_pkg::DATA_W-1:0];
            st      = aal_pkg::STAT_RECORDED;
          end
        end
      end
      aal_pkg::MODE_SEND: begin
        if (!hit_r) begin
          st = aal_pkg::STAT_INVALID;
        end else if (calc.cur.prv) begin
          st = aal_pkg::STAT_PROVEN;
        end else if (calc.snt_sum[aal_pkg::DATA_W] ||
                     (calc.snt_sum[aal_pkg::DATA_W-1:0] > calc.limit)) begin
          st = aal_pkg::STAT_LIMIT;
        end else begin
          res.snt = calc.snt_sum[aal_pkg::DATA_W-1:0];
          wr      = 1'b1;
          st      = aal_pkg::STAT_ALLOWED;
        end
      end
      aal_pkg::MODE_PROVE: begin
        if (hit_r) begin
          res.prv = 1'b1;
          wr      = 1'b1;
        end
      end
      aal_pkg::MODE_RELEASE: begin
        if (hit_r && !calc.rec_dif[aal_pkg::DATA_W] && !calc.snt_dif[aal_pkg::DATA_W]) begin
          res.rec = calc.rec_dif[aal_pkg::DATA_W-1:0];
          res.snt = calc.snt_dif[aal_pkg::DATA_W-1:0];
          if ((res.rec == '0) && (res.snt == '0)) begin
            free = 1'b1;
            keep = 1'b0;
          end else begin
            wr = 1'b1;
          end
        end
      end
      aal_pkg::MODE_ERASE: begin
        if (hit_r) begin
          free = 1'b1;
          keep = 1'b0;
        end
      end
      default: begin
        // query, and the unused codes that behave as query
      end
    endcase
  end

  // tag updates: clearing from a register write, otherwise from write-back
  always_comb begin
    upd       = '0;
    upd.clear = cfg_we && cfg_ok;
    upd.alloc = alloc && done_go;
    upd.free  = free && done_go;
    upd.idx   = idx_r;
    upd.key   = key_r;
  end

  always_comb begin
    if (alloc) begin
      cnt_after = tag_cnt + 1'b1;
    end else if (free) begin
      cnt_after = tag_cnt - 1'b1;
    end else begin
      cnt_after = tag_cnt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_status_r <= st;
      out_found_r  <= hit_r;
      out_acct_r   <= keep ? res : '0;
      out_used_r   <= 5'(cnt_after);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_entry_found    = out_found_r;
  assign out_received_total = out_acct_r.rec;
  assign out_sent_total     = out_acct_r.snt;
  assign out_proven_flag    = out_acct_r.prv;
  assign out_entries_in_use = out_used_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_LOOK)
    else $error("accepted request did not start a search");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result presented outside write-back");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_ok |=> tag_cnt == '0)
    else $error("register write did not clear the ledger");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

localparam int unsigned LIMIT_FACTOR = 3;

// one expected reply of the ledger
typedef struct packed {
  aal_pkg::status_t           status;
  logic                       found;
  logic [aal_pkg::DATA_W-1:0] rec;
  logic [aal_pkg::DATA_W-1:0] snt;
  logic                       prv;
  logic [4:0]                 in_use;
} ledger_reply_t;

// mirror of the ledger accounts plus the replies still owed by the block
class ledger_tracker;
  bit                       slot_used [aal_pkg::ENTRIES];
  bit [aal_pkg::KEY_W-1:0]  slot_key  [aal_pkg::ENTRIES];
  bit [aal_pkg::DATA_W-1:0] slot_rec  [aal_pkg::ENTRIES];
  bit [aal_pkg::DATA_W-1:0] slot_snt  [aal_pkg::ENTRIES];
  bit                       slot_prv  [aal_pkg::ENTRIES];
  int unsigned              occupied;
  int unsigned              active;
  ledger_reply_t            due_replies[$];
  int unsigned              mismatches;
  int unsigned              requests;
  int unsigned              replies;
  int unsigned              status_hits[8];

  function new();
    active = aal_pkg::ENTRIES;
    clear_ledger();
  endfunction

  function void clear_ledger();
    for (int i = 0; i < aal_pkg::ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_rec[i]  = '0;
      slot_snt[i]  = '0;
      slot_prv[i]  = 1'b0;
    end
    occupied = 0;
  endfunction

  // out-of-range sizes leave the ledger untouched
  function void set_active(bit [aal_pkg::CFG_W-1:0] value);
    if (value != 0 && value <= aal_pkg::ENTRIES) begin
      active = value;
      clear_ledger();
    end
  endfunction

  function int locate_slot(bit [aal_pkg::KEY_W-1:0] key);
    for (int i = 0; i < int'(active); i++) begin
      if (slot_used[i] && slot_key[i] == key) return i;
    end
    return -1;
  endfunction

  function int lowest_free();
    for (int i = 0; i < int'(active); i++) begin
      if (!slot_used[i]) return i;
    end
    return -1;
  endfunction

  // three times the received bytes, pinned at the top of the range
  function bit [aal_pkg::DATA_W-1:0] send_limit(bit [aal_pkg::DATA_W-1:0] rec);
    if (rec > {aal_pkg::DATA_W{1'b1}} / LIMIT_FACTOR) return {aal_pkg::DATA_W{1'b1}};
    return rec * LIMIT_FACTOR;
  endfunction

  function void drop_slot(int i);
    slot_used[i] = 1'b0;
    slot_key[i]  = '0;
    slot_rec[i]  = '0;
    slot_snt[i]  = '0;
    slot_prv[i]  = 1'b0;
    occupied--;
  endfunction

  // apply one accepted request and queue the reply it must produce
  function void log_request(bit [2:0] mode, bit [aal_pkg::KEY_W-1:0] key,
                            bit [aal_pkg::DATA_W-1:0] bytes,
                            bit [aal_pkg::DATA_W-1:0] srel);
    ledger_reply_t rep;
    int idx;
    requests++;
    idx = locate_slot(key);
    rep.status = aal_pkg::STAT_DONE;
    rep.found  = (idx >= 0);
    case (mode)
      aal_pkg::MODE_RECV: begin
        if (key == 0) begin
          rep.status = aal_pkg::STAT_INVALID;
        end else begin
          // new endpoint takes the lowest free slot
          if (idx < 0) begin
            idx = lowest_free();
            if (idx >= 0) begin
              slot_used[idx] = 1'b1;
              slot_key[idx]  = key;
              slot_rec[idx]  = '0;
              slot_snt[idx]  = '0;
              slot_prv[idx]  = 1'b0;
              occupied++;
            end
          end
          if (idx < 0) rep.status = aal_pkg::STAT_FULL;
          else if (slot_prv[idx]) rep.status = aal_pkg::STAT_PROVEN;
          else if (bytes > ~slot_rec[idx]) rep.status = aal_pkg::STAT_OVERFLOW;
          else begin
            slot_rec[idx] += bytes;
            rep.status = aal_pkg::STAT_RECORDED;
          end
        end
      end
      aal_pkg::MODE_SEND: begin
        if (idx < 0) rep.status = aal_pkg::STAT_INVALID;
        else if (slot_prv[idx]) rep.status = aal_pkg::STAT_PROVEN;
        else if (bytes > ~slot_snt[idx] ||
                 slot_snt[idx] + bytes > send_limit(slot_rec[idx])) begin
          rep.status = aal_pkg::STAT_LIMIT;
        end else begin
          slot_snt[idx] += bytes;
          rep.status = aal_pkg::STAT_ALLOWED;
        end
      end
      aal_pkg::MODE_PROVE: begin
        if (idx >= 0) slot_prv[idx] = 1'b1;
      end
      aal_pkg::MODE_RELEASE: begin
        // release only when both amounts fit, freeing an emptied account
        if (idx >= 0 && bytes <= slot_rec[idx] && srel <= slot_snt[idx]) begin
          slot_rec[idx] -= bytes;
          slot_snt[idx] -= srel;
          if (slot_rec[idx] == 0 && slot_snt[idx] == 0) begin
            drop_slot(idx);
            idx = -1;
          end
        end
      end
      aal_pkg::MODE_ERASE: begin
        if (idx >= 0) begin
          drop_slot(idx);
          idx = -1;
        end
      end
      default: ;
    endcase
    rep.rec    = (idx >= 0) ? slot_rec[idx] : '0;
    rep.snt    = (idx >= 0) ? slot_snt[idx] : '0;
    rep.prv    = (idx >= 0) ? slot_prv[idx] : 1'b0;
    rep.in_use = occupied[4:0];
    due_replies.push_back(rep);
  endfunction

  function void compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 200) begin
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field, want, got);
      end
    end
  endfunction

  // compare one reply against the oldest one owed
  function void check_reply(logic [2:0] status, logic found,
                            logic [aal_pkg::DATA_W-1:0] rec,
                            logic [aal_pkg::DATA_W-1:0] snt, logic prv,
                            logic [4:0] in_use);
    ledger_reply_t want;
    if (due_replies.size() == 0) begin
      mismatches++;
      $display("%0t ns: reply with none owed, expected nothing, actual status %0d",
               $time, status);
      return;
    end
    want = due_replies.pop_front();
    replies++;
    status_hits[want.status]++;
    compare_field("status", 64'(want.status), 64'(status));
    compare_field("entry_found", 64'(want.found), 64'(found));
    compare_field("received_total", want.rec, rec);
    compare_field("sent_total", want.snt, snt);
    compare_field("proven_flag", 64'(want.prv), 64'(prv));
    compare_field("entries_in_use", 64'(want.in_use), 64'(in_use));
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 110;
  localparam int POOL_KEYS     = 20;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [2:0]                 in_mode;
  logic [aal_pkg::KEY_W-1:0]  in_endpoint_key;
  logic [aal_pkg::DATA_W-1:0] in_byte_count;
  logic [aal_pkg::DATA_W-1:0] in_sent_release_count;
  logic                       out_valid;
  logic                       out_stall;
  logic [2:0]                 out_status;
  logic                       out_entry_found;
  logic [aal_pkg::DATA_W-1:0] out_received_total;
  logic [aal_pkg::DATA_W-1:0] out_sent_total;
  logic                       out_proven_flag;
  logic [4:0]                 out_entries_in_use;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [aal_pkg::CFG_W-1:0]  cfg_active_entries;

  ledger_tracker              book;
  int                         idle_pct;
  int                         stall_pct;
  int unsigned                cycle_count = 0;
  logic [aal_pkg::KEY_W-1:0]  key_pool [POOL_KEYS];
  logic [aal_pkg::CFG_W-1:0]  size_plan [PHASES];

  anti_amplification_ledger dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_mode               (in_mode),
    .in_endpoint_key       (in_endpoint_key),
    .in_byte_count         (in_byte_count),
    .in_sent_release_count (in_sent_release_count),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_entry_found       (out_entry_found),
    .out_received_total    (out_received_total),
    .out_sent_total        (out_sent_total),
    .out_proven_flag       (out_proven_flag),
    .out_entries_in_use    (out_entries_in_use),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_active_entries    (cfg_active_entries)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // reply checking and receiver back-pressure
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      book.check_reply(out_status, out_entry_found, out_received_total, out_sent_total,
                       out_proven_flag, out_entries_in_use);
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cycle limit of %0d reached with %0d replies owed",
               CYCLE_LIMIT, book.due_replies.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // present one request and hold it until the block takes it
  task automatic push_request(logic [2:0] mode, logic [aal_pkg::KEY_W-1:0] key,
                              logic [aal_pkg::DATA_W-1:0] bytes,
                              logic [aal_pkg::DATA_W-1:0] srel);
    in_valid              <= 1'b1;
    in_mode               <= mode;
    in_endpoint_key       <= key;
    in_byte_count         <= bytes;
    in_sent_release_count <= srel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.log_request(mode, key, bytes, srel);
  endtask

  // hold off until every owed reply is back, then let the pipeline settle
  task automatic drain_ledger();
    in_valid <= 1'b0;
    while (book.due_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_size(logic [aal_pkg::CFG_W-1:0] value);
    cfg_valid          <= 1'b1;
    cfg_active_entries <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.set_active(value);
    cfg_valid <= 1'b0;
  endtask

  // edge cases of every operation, with a two-entry ledger for the full case
  task automatic run_directed();
    logic [aal_pkg::KEY_W-1:0]  ka;
    logic [aal_pkg::KEY_W-1:0]  kb;
    logic [aal_pkg::KEY_W-1:0]  kc;
    logic [aal_pkg::DATA_W-1:0] top;
    ka  = {aal_pkg::KEY_W{1'b1}};
    kb  = 48'h0000_0000_0001;
    kc  = 48'h8000_0000_0000;
    top = {aal_pkg::DATA_W{1'b1}};
    push_request(aal_pkg::MODE_QUERY, ka, '0, '0);
    push_request(aal_pkg::MODE_RECV, '0, 64'd5, '0);
    push_request(aal_pkg::MODE_SEND, '0, 64'd1, '0);
    push_request(aal_pkg::MODE_SEND, ka, 64'd1, top);
    push_request(aal_pkg::MODE_RECV, ka, 64'd100, '0);
    push_request(aal_pkg::MODE_SEND, ka, 64'd300, '0);
    push_request(aal_pkg::MODE_SEND, ka, 64'd1, '0);
    push_request(aal_pkg::MODE_RECV, ka, top, '0);
    push_request(aal_pkg::MODE_RECV, kb, top, '0);
    push_request(aal_pkg::MODE_SEND, kb, top, '0);
    push_request(aal_pkg::MODE_SEND, kb, 64'd1, '0);
    push_request(aal_pkg::MODE_RELEASE, kb, 64'd1, top);
    push_request(aal_pkg::MODE_RELEASE, ka, 64'd101, '0);
    push_request(aal_pkg::MODE_RELEASE, ka, 64'd100, 64'd300);
    push_request(aal_pkg::MODE_PROVE, kb, '0, '0);
    push_request(aal_pkg::MODE_RECV, kb, 64'd1, '0);
    push_request(aal_pkg::MODE_SEND, kb, '0, '0);
    push_request(aal_pkg::MODE_ERASE, kb, '0, '0);
    push_request(aal_pkg::MODE_ERASE, kc, '0, '0);
    push_request(3'd6, ka, top, top);
    push_request(3'd7, kc, '0, '0);
    push_request(aal_pkg::MODE_PROVE, kc, '0, '0);
    drain_ledger();
    write_size(5'd2);
    push_request(aal_pkg::MODE_RECV, ka, '0, '0);
    push_request(aal_pkg::MODE_SEND, ka, '0, '0);
    push_request(aal_pkg::MODE_RECV, kb, 64'd7, '0);
    push_request(aal_pkg::MODE_RECV, kc, 64'd1, '0);
    push_request(aal_pkg::MODE_RELEASE, ka, '0, '0);
    push_request(aal_pkg::MODE_RECV, kc, 64'd1, '0);
    drain_ledger();
  endtask

  // random request biased towards live accounts and amounts near the limits
  task automatic random_request();
    logic [2:0]                 mode;
    logic [aal_pkg::KEY_W-1:0]  key;
    logic [aal_pkg::DATA_W-1:0] bytes;
    logic [aal_pkg::DATA_W-1:0] srel;
    logic [aal_pkg::DATA_W-1:0] room;
    logic [aal_pkg::DATA_W-1:0] lim;
    int                         pick;
    int                         slot;
    pick = $urandom_range(0, 99);
    if (pick < 34)      mode = aal_pkg::MODE_RECV;
    else if (pick < 62) mode = aal_pkg::MODE_SEND;
    else if (pick < 67) mode = aal_pkg::MODE_PROVE;
    else if (pick < 79) mode = aal_pkg::MODE_RELEASE;
    else if (pick < 86) mode = aal_pkg::MODE_ERASE;
    else if (pick < 93) mode = aal_pkg::MODE_QUERY;
    else if (pick < 96) mode = 3'd6;
    else                mode = 3'd7;
    pick = $urandom_range(0, 99);
    if (pick < 4)      key = '0;
    else if (pick < 9) key = aal_pkg::KEY_W'(rand64());
    else               key = key_pool[$urandom_range(0, book.active + 3)];
    slot  = book.locate_slot(key);
    bytes = rand64();
    srel  = rand64();
    pick  = $urandom_range(0, 99);
    case (mode)
      aal_pkg::MODE_RECV: begin
        if (pick < 60)      bytes = 64'($urandom_range(0, 4000));
        else if (pick < 78) bytes = {32'd0, $urandom()};
        else if (pick > 94) bytes = ~64'($urandom_range(0, 100));
      end
      aal_pkg::MODE_SEND: begin
        if (slot >= 0) begin
          lim  = book.send_limit(book.slot_rec[slot]);
          room = (lim > book.slot_snt[slot]) ? lim - book.slot_snt[slot] : '0;
          if (pick < 45)      bytes = room >> $urandom_range(0, 3);
          else if (pick < 60) bytes = room + 1;
          else if (pick < 80) bytes = 64'($urandom_range(0, 4000));
        end else if (pick < 70) begin
          bytes = 64'($urandom_range(0, 4000));
        end
      end
      aal_pkg::MODE_RELEASE: begin
        if (slot >= 0 && pick < 40) begin
          bytes = book.slot_rec[slot];
          srel  = book.slot_snt[slot];
        end else if (slot >= 0 && pick < 75) begin
          bytes = book.slot_rec[slot] >> $urandom_range(0, 6);
          srel  = book.slot_snt[slot] >> $urandom_range(0, 6);
        end
      end
      default: ;
    endcase
    push_request(mode, key, bytes, srel);
  endtask

  // stimulus
  initial begin
    book                  = new();
    rst_n                 <= 1'b0;
    in_valid              <= 1'b0;
    in_mode               <= '0;
    in_endpoint_key       <= '0;
    in_byte_count         <= '0;
    in_sent_release_count <= '0;
    cfg_valid             <= 1'b0;
    cfg_active_entries    <= '0;
    idle_pct              = 0;
    stall_pct             = 0;
    size_plan = '{5'd16, 5'd1, 5'd16, 5'd5, 5'd0, 5'd12, 5'd31, 5'd3, 5'd17, 5'd16};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      drain_ledger();
      write_size(size_plan[p]);
      // fresh endpoint keys for every phase
      foreach (key_pool[i]) begin
        key_pool[i] = aal_pkg::KEY_W'(rand64());
        if (key_pool[i] == 0) key_pool[i] = aal_pkg::KEY_W'(i + 1);
      end
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // halfway through phase 2 the sender waits for every reply before carrying on
        if (p == 2 && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          while (book.due_replies.size() != 0) @(posedge clk);
        end
        while ($urandom_range(0, 99) < idle_pct) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
        random_request();
      end
    end

    drain_ledger();
    $display("run covered %0d requests and %0d replies across %0d size register writes",
             book.requests, book.replies, PHASES + 1);
    $display("status mix rec %0d allow %0d inval %0d full %0d",
             book.status_hits[aal_pkg::STAT_RECORDED],
             book.status_hits[aal_pkg::STAT_ALLOWED],
             book.status_hits[aal_pkg::STAT_INVALID],
             book.status_hits[aal_pkg::STAT_FULL]);
    $display("  prov %0d ovf %0d lim %0d done %0d",
             book.status_hits[aal_pkg::STAT_PROVEN],
             book.status_hits[aal_pkg::STAT_OVERFLOW],
             book.status_hits[aal_pkg::STAT_LIMIT],
             book.status_hits[aal_pkg::STAT_DONE]);
    if (book.mismatches == 0 && book.due_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
